### rtl/base32_stream_encoder_macros.svh
// Assertion macros for the base32 stream encoder.
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define B32E_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define B32E_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/b32e_pkg.sv
// Types, constants and the character function shared by the base32 encoder.
package b32e_pkg;

   localparam int unsigned SYM_W = 5;
   localparam int unsigned SLOTS = 3;

   localparam logic [7:0]       CHAR_A        = 8'h41;
   localparam logic [7:0]       CHAR_TWO      = 8'h32;
   localparam logic [SYM_W-1:0] LETTER_COUNT  = 5'd26;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_end;
      logic       message_end;
   } rsp_type;

   // One decoded byte: up to three symbols, how many are live, end of message.
   typedef struct packed {
      logic [SLOTS-1:0][SYM_W-1:0] syms;
      logic [1:0]                  count;
      logic                        last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic [2:0] leftover_count;
   } front_stat_type;

   function automatic logic [7:0] b32_char(input logic [SYM_W-1:0] v);
      logic [7:0] res;
      if (v < LETTER_COUNT) begin
         res = CHAR_A + {3'b000, v};
      end else begin
         res = CHAR_TWO + {3'b000, v} - {3'b000, LETTER_COUNT};
      end
      return res;
   endfunction

endpackage

### rtl/b32e_front.sv
// Front end: takes bytes, joins them to leftover bits and splits out 5-bit groups.
module b32e_front
   import b32e_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   input  fifo_stat_type  fifo_stat,
   output logic           push,
   output job_type        job,
   output front_stat_type front_stat
);

   logic [3:0]  lo_bits_ff, lo_bits_in;
   logic [2:0]  lo_cnt_ff, lo_cnt_in;
   logic [11:0] acc;
   logic [3:0]  n;
   logic [14:0] al;
   logic        two_groups;
   logic [2:0]  rem;
   logic        pad;
   logic [3:0]  rem_mask;

   always_comb begin
      acc        = {lo_bits_ff, req_data.data_byte};
      n          = {1'b0, lo_cnt_ff} + 4'd8;
      al         = 15'({acc, 3'b000} << (3'd4 - lo_cnt_ff));
      two_groups = (n >= 4'd10);
      rem        = two_groups ? 3'(n - 4'd10) : 3'(n - 4'd5);
      pad        = req_data.last_byte && (rem != 3'd0);
      rem_mask   = 4'((5'd1 << rem) - 5'd1);

      job.syms[0] = al[14:10];
      job.syms[1] = al[9:5];
      job.syms[2] = al[4:0];
      job.count   = (two_groups ? 2'd2 : 2'd1) + {1'b0, pad};
      job.last    = req_data.last_byte;

      req_ready = !fifo_stat.full;
      push      = req_valid && !fifo_stat.full;

      lo_bits_in = lo_bits_ff;
      lo_cnt_in  = lo_cnt_ff;
      if (push) begin
         if (req_data.last_byte) begin
            lo_bits_in = 4'd0;
            lo_cnt_in  = 3'd0;
         end else begin
            lo_bits_in = acc[3:0] & rem_mask;
            lo_cnt_in  = rem;
         end
      end

      front_stat.leftover_count = lo_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_bits_ff <= 4'd0;
         lo_cnt_ff  <= 3'd0;
      end else begin
         lo_bits_ff <= lo_bits_in;
         lo_cnt_ff  <= lo_cnt_in;
      end
   end

endmodule

### rtl/b32e_fifo.sv
// Short queue of decoded jobs between the front and back ends.
module b32e_fifo
   import b32e_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  job_type       job_in,
   input  logic          pop,
   output job_type       job_out,
   output fifo_stat_type stat
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type         mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   always_comb begin
      stat.full  = (cnt_ff == FULL_CNT);
      stat.empty = (cnt_ff == '0);
      do_push    = push && !stat.full;
      do_pop     = pop && !stat.empty;
      job_out    = mem[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### rtl/b32e_back.sv
// Back end: walks each job's symbols; one character per unstalled cycle.
module b32e_back
   import b32e_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  job_type       job,
   input  fifo_stat_type fifo_stat,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   logic [1:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             load;
   logic             final_sym;
   logic [SYM_W-1:0] sym;

   always_comb begin
      unique case (idx_ff)
         2'd0:    sym = job.syms[0];
         2'd1:    sym = job.syms[1];
         default: sym = job.syms[2];
      endcase

      load      = !fifo_stat.empty && (!rsp_valid_ff || rsp_ready);
      final_sym = (idx_ff == job.count - 2'd1);
      pop       = load && final_sym;

      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_ready ? 1'b0 : rsp_valid_ff;
      idx_in             = idx_ff;
      if (load) begin
         rsp_in.out_char    = b32_char(sym);
         rsp_in.run_end     = final_sym;
         rsp_in.message_end = final_sym && job.last;
         rsp_valid_in       = 1'b1;
         idx_in             = final_sym ? 2'd0 : idx_ff + 2'd1;
      end

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/base32_stream_encoder.sv
// Top level of the streaming base32 encoder.
//
// Input channel req_*: one message byte per item with a flag on its final byte.
// Output channel rsp_*: one ASCII base32 character per item ('A'-'Z', '2'-'7'),
// most significant bits first, no '=' padding. run_end marks the last character
// caused by a byte, message_end the final character of the message.
// Each byte gives one to three characters; the output stage hands out one
// character per cycle while the receiver is ready, so sustained throughput is
// set by the single-character output register.
// An accepted byte is first written into the job queue; when nothing waits ahead
// of it, its first character is then loaded into the output register.
// The front end takes a new byte every cycle while the job queue has room
// (FIFO_DEPTH jobs), independent of the output side.
// When the receiver stalls the character holds in the output register, the
// queue fills, and req_ready drops once it is full.
// Reset clears the leftover bits, the queue and the output valid; a new
// message starts after reset and after every byte flagged last.
`include "base32_stream_encoder_macros.svh"

module base32_stream_encoder
   import b32e_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   fifo_stat_type  fifo_stat;
   front_stat_type front_stat;
   job_type        job_wr, job_rd;
   logic           push, pop;

   b32e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .fifo_stat  (fifo_stat),
      .push       (push),
      .job        (job_wr),
      .front_stat (front_stat)
   );

   b32e_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (job_wr),
      .pop     (pop),
      .job_out (job_rd),
      .stat    (fifo_stat)
   );

   b32e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job_rd),
      .fifo_stat (fifo_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `B32E_ASSERT_NOW(a_leftover_range, 1'b1, front_stat.leftover_count <= 3'd4, "leftover count above four")
   `B32E_ASSERT_NEXT(a_last_clears, req_valid && req_ready && req_data.last_byte, front_stat.leftover_count == 3'd0, "leftover not cleared after last byte")
   `B32E_ASSERT_NOW(a_msg_end_run_end, rsp_valid && rsp_data.message_end, rsp_data.run_end, "message end without run end")
   `B32E_ASSERT_NOW(a_alphabet, rsp_valid, (rsp_data.out_char >= CHAR_A && rsp_data.out_char <= 8'h5A) || (rsp_data.out_char >= CHAR_TWO && rsp_data.out_char <= 8'h37), "character outside alphabet")

endmodule

### dv/base32_stream_encoder_tb.sv
`timescale 1ns / 1ps
// Testbench for the streaming base32 encoder: directed and random messages checked by a scoreboard.
module base32_stream_encoder_tb;
   import b32e_pkg::*;

   localparam int RANDOM_BYTES = 400;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_GAP      = 12;

   class encoder_scoreboard;
      logic [3:0] spare_bits;
      logic [2:0] spare_count;
      rsp_type    pending_chars[$];
      int         errors;

      function void clear();
         spare_bits  = '0;
         spare_count = '0;
         errors      = 0;
         pending_chars.delete();
      endfunction

      function logic [7:0] symbol_to_ascii(input logic [4:0] sym);
         if (sym < 5'd26) begin
            return 8'h41 + sym;
         end else begin
            return 8'h32 + (sym - 5'd26);
         end
      endfunction

      // Work out the characters one accepted byte gives and queue them.
      function void note_byte(input req_type item);
         logic [11:0] acc;
         int          n;
         int          k;
         rsp_type     ch;
         rsp_type     chars[$];
         acc = {spare_bits, item.data_byte};
         n   = int'(spare_count) + 8;
         while (n >= 5) begin
            ch.out_char    = symbol_to_ascii(5'(acc >> (n - 5)));
            ch.run_end     = 1'b0;
            ch.message_end = 1'b0;
            chars.push_back(ch);
            n -= 5;
         end
         acc = acc & ((12'd1 << n) - 12'd1);
         if (item.last_byte) begin
            if (n > 0) begin
               ch.out_char    = symbol_to_ascii(5'(acc << (5 - n)));
               ch.run_end     = 1'b0;
               ch.message_end = 1'b0;
               chars.push_back(ch);
            end
            spare_bits  = '0;
            spare_count = '0;
         end else begin
            spare_bits  = acc[3:0];
            spare_count = 3'(n);
         end
         k = chars.size() - 1;
         ch = chars[k];
         ch.run_end     = 1'b1;
         ch.message_end = item.last_byte;
         chars[k] = ch;
         foreach (chars[i]) pending_chars.push_back(chars[i]);
      endfunction

      function void check_char(input rsp_type got);
         rsp_type want;
         if (pending_chars.size() == 0) begin
            $error("unexpected character: out_char %h run_end %b message_end %b",
                   got.out_char, got.run_end, got.message_end);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (got.out_char !== want.out_char) begin
            $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
            errors++;
         end
         if (got.run_end !== want.run_end) begin
            $error("run_end: expected %b, actual %b", want.run_end, got.run_end);
            errors++;
         end
         if (got.message_end !== want.message_end) begin
            $error("message_end: expected %b, actual %b", want.message_end, got.message_end);
            errors++;
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   encoder_scoreboard sb;
   bit no_idle = 1'b0;
   int idle_cycles = 0;
   int bytes_sent = 0;

   base32_stream_encoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int draw_gap();
      if (no_idle) begin
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      int      gap;
      req_type item;
      gap = draw_gap();
      item.data_byte = value;
      item.last_byte = last;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(item);
      bytes_sent++;
   endtask

   task automatic send_random_message();
      int len;
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom), i == len - 1);
      end
   endtask

   task automatic take_chars();
      int gap;
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_char(rsp_data);
      end
   endtask

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      sb = new();
      sb.clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      fork
         take_chars();
      join_none

      // one-byte messages at both extremes
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // five bytes end on a group boundary, so no padding character
      no_idle = 1'b1;
      for (int i = 0; i < 5; i++) send_byte(8'hFF, i == 4);
      no_idle = 1'b0;
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7C, 1'b0);
      send_byte(8'h03, 1'b1);

      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         no_idle = ($urandom_range(0, 3) == 0);
         send_random_message();
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
